[hdl/shiprrip_pkg.sv]
// ----------------------------------------------------------------------------
// shiprrip_pkg
// Shared codes and fixed constants of the SHiP-lite SRRIP replacement policy
// with per-set stream bypass.
// ----------------------------------------------------------------------------
package shiprrip_pkg;

  // Command carried in tuser
  typedef enum logic [0:0] {
    CMD_VICTIM = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  // Input field widths (fixed by the stream format)
  localparam int unsigned SET_IN_W  = 11;
  localparam int unsigned WAY_IN_W  = 4;
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned SIG_IN_W  = 6;
  localparam int unsigned SIG_MAX_W = 14;
  localparam int unsigned CFG_W     = 4;

  // Line address
  localparam int unsigned LINE_SHIFT = 6;
  localparam int unsigned LINE_W     = ADDR_W - LINE_SHIFT;

  // RRPV values
  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] RRPV_NEAR = 2'd1;
  localparam logic [1:0] RRPV_HIT  = 2'd0;

  // Outcome counters and stride detector
  localparam logic [1:0] CNT_SAT     = 2'd3;
  localparam logic [1:0] CNT_INIT    = 2'd1;
  localparam logic [1:0] CNT_NEAR_TH = 2'd2;
  localparam logic [1:0] STRIDE_SAT  = 2'd3;

  // Reset value of the stream window register
  localparam logic [CFG_W-1:0] WIN_RESET = 4'd8;

endpackage

[hdl/ship_rrip_stream_bypass_policy_unit.sv]
// ----------------------------------------------------------------------------
// ship_rrip_stream_bypass_policy_unit
// Victim: modulo, set-row read and search, then the result is registered and the
// next transaction is taken, unless a previous result still waits at the output.
// Update: modulo, set-row read and outcome-counter read-modify-write, plus a fill
// step on a miss; a way beyond NUM_WAYS ends after the modulo. After reset, a
// clearing pass over max(NUM_SETS, 2**SIG_BITS) entries initialises both memories, no input taken.
// ----------------------------------------------------------------------------
module ship_rrip_stream_bypass_policy_unit #(
  parameter int unsigned NUM_SETS = 2048,
  parameter int unsigned NUM_WAYS = 16,
  parameter int unsigned SIG_BITS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: stream_window
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: set_index[10:0], way_index[14:11], phys_addr[62:15],
  //        pc_signature[68:63], is_hit[69], zero pad[71:70]
  input  logic [71:0] s_axis_tdata,
  // tuser: command[0]
  input  logic [0:0]  s_axis_tuser,
  // victim stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: victim_way[3:0], zero pad[7:4]
  output logic [7:0]  m_axis_tdata
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int unsigned SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WAY_W  = $clog2(NUM_WAYS);
  localparam int unsigned TABLE  = 1 << SIG_BITS;
  localparam int unsigned RV_W   = 2 * NUM_WAYS;
  localparam int unsigned SG_W   = SIG_BITS * NUM_WAYS;
  localparam int unsigned LINE_W = shiprrip_pkg::LINE_W;
  localparam int unsigned DET_W  = LINE_W + 2 + 1 + shiprrip_pkg::CFG_W;
  localparam int unsigned SG_LO  = RV_W;
  localparam int unsigned DET_LO = RV_W + SG_W;
  localparam int unsigned ROW_W  = RV_W + SG_W + DET_W;
  localparam int unsigned RUN_LO = DET_LO + LINE_W;
  localparam int unsigned FLG_B  = RUN_LO + 2;
  localparam int unsigned WIN_LO = FLG_B + 1;
  localparam int unsigned CLR_N  = (NUM_SETS > TABLE) ? NUM_SETS : TABLE;
  localparam int unsigned CLR_W  = $clog2(CLR_N + 1);

  // set reduction by reciprocal multiplication
  localparam int unsigned  RECIP_SH = 22;
  localparam logic [63:0]  RECIP_L  = (64'd1 << RECIP_SH) / NUM_SETS;
  localparam logic [22:0]  RECIP    = RECIP_L[22:0];
  localparam logic [16:0]  NSETS17  = 17'(NUM_SETS);
  localparam logic [5:0]   NWAYS6   = 6'(NUM_WAYS);

  localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'({NUM_WAYS{shiprrip_pkg::RRPV_MAX}});

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_MOD1, ST_MOD2, ST_RD,
    ST_ROWV, ST_VOUT, ST_ROWU, ST_CNT1, ST_CNT2
  } state_e;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                       state_q, state_d;
  logic [CLR_W-1:0]             clr_cnt_q, clr_cnt_d;
  logic [shiprrip_pkg::CFG_W-1:0] win_cfg_q, win_cfg_d;
  shiprrip_pkg::cmd_e           cmd_q, cmd_d;
  logic [10:0]                  set_q, set_d;
  logic [3:0]                   way_q, way_d;
  logic [LINE_W-1:0]            line_q, line_d;
  logic [SIG_BITS-1:0]          sig_q, sig_d;
  logic                         hit_q, hit_d;
  logic [10:0]                  quo_q, quo_d;
  logic [16:0]                  rem_q, rem_d;
  logic [SET_W-1:0]             sadr_q, sadr_d;
  logic [ROW_W-1:0]             row_q, row_d;
  logic [SIG_BITS-1:0]          old_q, old_d;
  logic                         byp_q, byp_d;
  logic [1:0]                   dec_q, dec_d;
  logic [3:0]                   vic_q, vic_d;
  logic                         out_valid_q, out_valid_d;
  logic [3:0]                   out_way_q, out_way_d;

  // memory ports
  logic                         row_we, row_re;
  logic [SET_W-1:0]             row_wa, row_ra;
  logic [ROW_W-1:0]             row_wd, row_rd_q;
  logic                         cnt_we, cnt_re;
  logic [SIG_BITS-1:0]          cnt_wa, cnt_ra;
  logic [1:0]                   cnt_wd, cnt_rd_q;

  // --------------------------------------------------------------------------
  // Memories: per-set row (RRPVs, signatures, stream detector), counters
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] row_mem [NUM_SETS];
  logic [1:0]       cnt_mem [TABLE];

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (row_re) begin
      row_rd_q <= row_mem[row_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_ra];
    end
  end

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  localparam int unsigned SIG_MAX_W_L = shiprrip_pkg::SIG_MAX_W;
  logic [SIG_MAX_W_L-1:0] sig_ext;
  logic [shiprrip_pkg::ADDR_W-1:0] in_addr;

  assign in_addr = s_axis_tdata[62:15];
  assign sig_ext = SIG_MAX_W_L'(s_axis_tdata[68:63]);

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic [33:0]        prod_recip;
  logic [27:0]        prod_back;
  logic [16:0]        rem_fix;
  logic [4:0]         way5;
  logic [WAY_W-1:0]   wa;
  logic               way_ok;

  assign prod_recip = 34'(set_q) * 34'(RECIP);
  assign prod_back  = 28'(quo_q) * 28'(NSETS17);
  assign rem_fix    = (rem_q >= NSETS17) ? (rem_q - NSETS17) : rem_q;
  assign way5       = {1'b0, way_q};
  assign wa         = way5[WAY_W-1:0];
  assign way_ok     = {2'b00, way_q} < NWAYS6;

  // victim search over the row just read
  logic             fnd3, fnd2;
  logic [WAY_W-1:0] idx3, idx2, vsel;
  logic [4:0]       vsel5;
  logic [RV_W-1:0]  rv_aged;

  always_comb begin
    fnd3    = 1'b0;
    fnd2    = 1'b0;
    idx3    = '0;
    idx2    = '0;
    rv_aged = row_rd_q[RV_W-1:0];
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row_rd_q[2*w +: 2] == shiprrip_pkg::RRPV_MAX) begin
        fnd3 = 1'b1;
        idx3 = WAY_W'(w);
      end
      if (row_rd_q[2*w +: 2] == 2'd2) begin
        fnd2 = 1'b1;
        idx2 = WAY_W'(w);
      end
      rv_aged[2*w +: 2] = row_rd_q[2*w +: 2] + 2'd1;
    end
    if (fnd3) begin
      vsel = idx3;
    end else if (fnd2) begin
      vsel = idx2;
    end else begin
      vsel = '0;
    end
  end

  assign vsel5 = 5'(vsel);

  // stream detector training
  logic [LINE_W-1:0]  last_line;
  logic [1:0]         run_o, run_n;
  logic               flag_o, flag_n;
  logic [3:0]         win_o, win_n;
  logic               unit_stride;
  logic [SIG_BITS-1:0] old_sig;

  always_comb begin
    last_line   = row_rd_q[DET_LO +: LINE_W];
    run_o       = row_rd_q[RUN_LO +: 2];
    flag_o      = row_rd_q[FLG_B];
    win_o       = row_rd_q[WIN_LO +: 4];
    unit_stride = (last_line != '0) &&
                  (({1'b0, line_q} == ({1'b0, last_line} + 43'd1)) ||
                   ({1'b0, last_line} == ({1'b0, line_q} + 43'd1)));
    run_n  = 2'd0;
    flag_n = 1'b0;
    win_n  = 4'd0;
    if (unit_stride) begin
      run_n  = (run_o < shiprrip_pkg::STRIDE_SAT) ? run_o + 2'd1 : run_o;
      flag_n = flag_o;
      win_n  = win_o;
      if (run_n == shiprrip_pkg::STRIDE_SAT && !flag_o) begin
        flag_n = 1'b1;
        win_n  = win_cfg_q;
      end
    end
    if (flag_n && win_n != 4'd0) begin
      win_n = win_n - 4'd1;
    end
    old_sig = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (wa == WAY_W'(w)) begin
        old_sig = row_rd_q[SG_LO + w*SIG_BITS +: SIG_BITS];
      end
    end
  end

  // insertion RRPV on a miss
  logic [1:0] cnt_new;
  logic [1:0] fill_rrpv;

  assign cnt_new   = (sig_q == old_q) ? dec_q : cnt_rd_q;
  assign fill_rrpv = byp_q ? shiprrip_pkg::RRPV_MAX :
                     (cnt_new >= shiprrip_pkg::CNT_NEAR_TH) ? shiprrip_pkg::RRPV_NEAR :
                                                             shiprrip_pkg::RRPV_MAX;

  // --------------------------------------------------------------------------
  // Control and next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    win_cfg_d   = cfg_we_i ? cfg_wdata_i : win_cfg_q;
    cmd_d       = cmd_q;
    set_d       = set_q;
    way_d       = way_q;
    line_d      = line_q;
    sig_d       = sig_q;
    hit_d       = hit_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    sadr_d      = sadr_q;
    row_d       = row_q;
    old_d       = old_q;
    byp_d       = byp_q;
    dec_d       = dec_q;
    vic_d       = vic_q;
    out_valid_d = out_valid_q;
    out_way_d   = out_way_q;

    row_we = 1'b0;
    row_re = 1'b0;
    row_wa = sadr_q;
    row_ra = sadr_q;
    row_wd = row_q;
    cnt_we = 1'b0;
    cnt_re = 1'b0;
    cnt_wa = sig_q;
    cnt_ra = sig_q;
    cnt_wd = shiprrip_pkg::CNT_INIT;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // clearing pass over both memories
      ST_CLR: begin
        row_we    = clr_cnt_q < CLR_W'(NUM_SETS);
        row_wa    = clr_cnt_q[SET_W-1:0];
        row_wd    = ROW_RESET;
        cnt_we    = clr_cnt_q < CLR_W'(TABLE);
        cnt_wa    = clr_cnt_q[SIG_BITS-1:0];
        cnt_wd    = shiprrip_pkg::CNT_INIT;
        clr_cnt_d = clr_cnt_q + CLR_W'(1);
        if (clr_cnt_q == CLR_W'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = shiprrip_pkg::cmd_e'(s_axis_tuser[0]);
          set_d   = s_axis_tdata[10:0];
          way_d   = s_axis_tdata[14:11];
          line_d  = in_addr[shiprrip_pkg::ADDR_W-1:shiprrip_pkg::LINE_SHIFT];
          sig_d   = sig_ext[SIG_BITS-1:0];
          hit_d   = s_axis_tdata[69];
          state_d = ST_MOD1;
        end
      end
      // set_index modulo NUM_SETS: quotient estimate, then remainder
      ST_MOD1: begin
        quo_d   = prod_recip[32:22];
        state_d = ST_MOD2;
      end
      ST_MOD2: begin
        rem_d   = 17'(set_q) - prod_back[16:0];
        state_d = ST_RD;
      end
      ST_RD: begin
        sadr_d = rem_fix[SET_W-1:0];
        row_ra = rem_fix[SET_W-1:0];
        if (cmd_q == shiprrip_pkg::CMD_VICTIM) begin
          row_re  = 1'b1;
          state_d = ST_ROWV;
        end else if (way_ok) begin
          row_re  = 1'b1;
          state_d = ST_ROWU;
        end else begin
          state_d = ST_IDLE;
        end
      end
      // victim: search, age the set when nothing sits at the distant value
      ST_ROWV: begin
        vic_d = vsel5[3:0];
        if (!fnd3) begin
          row_we = 1'b1;
          row_wd = {row_rd_q[ROW_W-1:RV_W], rv_aged};
        end
        state_d = ST_VOUT;
      end
      ST_VOUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_way_d   = vic_q;
          state_d     = ST_IDLE;
        end
      end
      // update: train detector, fetch the counter to adjust
      ST_ROWU: begin
        row_d = row_rd_q;
        row_d[DET_LO +: LINE_W] = line_q;
        row_d[RUN_LO +: 2]      = run_n;
        row_d[FLG_B]            = flag_n;
        row_d[WIN_LO +: 4]      = win_n;
        old_d  = old_sig;
        byp_d  = flag_n && (win_n != 4'd0);
        cnt_re = 1'b1;
        cnt_ra = hit_q ? sig_q : old_sig;
        state_d = ST_CNT1;
      end
      ST_CNT1: begin
        cnt_we = 1'b1;
        if (hit_q) begin
          cnt_wa = sig_q;
          cnt_wd = (cnt_rd_q < shiprrip_pkg::CNT_SAT) ? cnt_rd_q + 2'd1 : cnt_rd_q;
          row_we = 1'b1;
          for (int w = 0; w < NUM_WAYS; w++) begin
            if (wa == WAY_W'(w)) begin
              row_wd[2*w +: 2] = shiprrip_pkg::RRPV_HIT;
            end
          end
          state_d = ST_IDLE;
        end else begin
          cnt_wa = old_q;
          cnt_wd = (cnt_rd_q != 2'd0) ? cnt_rd_q - 2'd1 : cnt_rd_q;
          dec_d  = cnt_wd;
          // read the access signature's counter; same entry is forwarded
          cnt_re = 1'b1;
          cnt_ra = sig_q;
          state_d = ST_CNT2;
        end
      end
      ST_CNT2: begin
        row_we = 1'b1;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (wa == WAY_W'(w)) begin
            row_wd[2*w +: 2]                         = fill_rrpv;
            row_wd[SG_LO + w*SIG_BITS +: SIG_BITS]   = sig_q;
          end
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State and registered outputs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      win_cfg_q   <= shiprrip_pkg::WIN_RESET;
      cmd_q       <= shiprrip_pkg::CMD_VICTIM;
      set_q       <= '0;
      way_q       <= '0;
      line_q      <= '0;
      sig_q       <= '0;
      hit_q       <= 1'b0;
      quo_q       <= '0;
      rem_q       <= '0;
      sadr_q      <= '0;
      row_q       <= '0;
      old_q       <= '0;
      byp_q       <= 1'b0;
      dec_q       <= '0;
      vic_q       <= '0;
      out_valid_q <= 1'b0;
      out_way_q   <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      win_cfg_q   <= win_cfg_d;
      cmd_q       <= cmd_d;
      set_q       <= set_d;
      way_q       <= way_d;
      line_q      <= line_d;
      sig_q       <= sig_d;
      hit_q       <= hit_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      sadr_q      <= sadr_d;
      row_q       <= row_d;
      old_q       <= old_d;
      byp_q       <= byp_d;
      dec_q       <= dec_d;
      vic_q       <= vic_d;
      out_valid_q <= out_valid_d;
      out_way_q   <= out_way_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_way_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous transaction still in flight");

  a_result_from_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (cmd_q == shiprrip_pkg::CMD_VICTIM))
    else $error("result raised for an update transaction");

  a_counter_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CNT2) |-> ($past(state_q) == ST_CNT1))
    else $error("insertion step reached without counter decrement");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SHiP-lite SRRIP replacement unit with stream
// bypass. A queue-fed driver offers victim and update transactions and a
// monitor predicts every victim way from its own copy of the policy state.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned NSETS        = 2048;
  localparam int unsigned NWAYS        = 16;
  localparam int unsigned SIGW         = 6;
  localparam int unsigned NSIGS        = 1 << SIGW;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned WDOG_LIMIT   = 8000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NPHASES      = 6;

  // field widths taken from the package
  localparam int unsigned SET_IN_W   = shiprrip_pkg::SET_IN_W;
  localparam int unsigned WAY_IN_W   = shiprrip_pkg::WAY_IN_W;
  localparam int unsigned ADDR_W     = shiprrip_pkg::ADDR_W;
  localparam int unsigned SIG_IN_W   = shiprrip_pkg::SIG_IN_W;
  localparam int unsigned LINE_W     = shiprrip_pkg::LINE_W;
  localparam int unsigned LINE_SHIFT = shiprrip_pkg::LINE_SHIFT;
  localparam int unsigned CFG_W      = shiprrip_pkg::CFG_W;

  typedef struct {
    shiprrip_pkg::cmd_e  cmd;
    logic [SET_IN_W-1:0] set_idx;
    logic [WAY_IN_W-1:0] way;
    logic [ADDR_W-1:0]   addr;
    logic [SIG_IN_W-1:0] sig;
    logic                hit;
  } llc_req_t;

  typedef struct {
    logic [SET_IN_W-1:0] set_idx;
    logic [WAY_IN_W-1:0] way;
  } victim_due_t;

  // DUT ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [3:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  ship_rrip_stream_bypass_policy_unit #(
    .NUM_SETS(NSETS),
    .NUM_WAYS(NWAYS),
    .SIG_BITS(SIGW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predicted policy state
  bit [1:0]        rrpv_m      [NSETS*NWAYS];
  bit [SIGW-1:0]   wsig_m      [NSETS*NWAYS];
  bit [1:0]        reuse_ctr   [NSIGS];
  bit [LINE_W-1:0] last_line   [NSETS];
  bit [1:0]        stride_cnt  [NSETS];
  bit              stream_on   [NSETS];
  bit [3:0]        bypass_left [NSETS];
  bit [CFG_W-1:0]  window_len;

  // Bench bookkeeping
  llc_req_t      req_pending_q[$];
  victim_due_t   victim_due_q[$];
  victim_due_t   due;
  llc_req_t      nxt;
  logic [SIG_IN_W-1:0] sig_pool[8];
  logic [SET_IN_W-1:0] hot_sets[8];
  bit            req_fire, rsp_fire;
  bit            src_gaps, sink_stalls;
  int unsigned   gap_left, stall_left, hold_left;
  int unsigned   hold_reqs, holds_done;
  int unsigned   n_queued, n_accepted, n_victims, n_updates;
  int unsigned   n_stream_starts, n_cfg_writes, errors, idle_cycles;

  // --------------------------------------------------------------------------
  // Policy predictor
  // --------------------------------------------------------------------------
  function automatic int first_at_max(int unsigned base);
    for (int w = 0; w < NWAYS; w++)
      if (rrpv_m[base + w] == shiprrip_pkg::RRPV_MAX) return w;
    return -1;
  endfunction

  function automatic logic [WAY_IN_W-1:0] pick_victim_way(int unsigned s);
    int unsigned base;
    int          found;
    base  = s * NWAYS;
    found = first_at_max(base);
    if (found < 0) begin
      // age the whole set once, then search again
      for (int w = 0; w < NWAYS; w++)
        if (rrpv_m[base + w] != shiprrip_pkg::RRPV_MAX) rrpv_m[base + w]++;
      found = first_at_max(base);
    end
    return (found < 0) ? '0 : WAY_IN_W'(found);
  endfunction

  function automatic void train_stride_detector(int unsigned s, bit [LINE_W-1:0] line);
    bit [LINE_W:0] prev, cur;
    bit            unit;
    prev = {1'b0, last_line[s]};
    cur  = {1'b0, line};
    // a previous line of zero never counts
    unit = (prev != 0) && ((cur == prev + 1) || (prev == cur + 1));
    if (unit) begin
      if (stride_cnt[s] != shiprrip_pkg::STRIDE_SAT) stride_cnt[s]++;
      if (stride_cnt[s] == shiprrip_pkg::STRIDE_SAT && !stream_on[s]) begin
        stream_on[s]   = 1'b1;
        bypass_left[s] = window_len;
        n_stream_starts++;
      end
    end else begin
      stride_cnt[s]  = '0;
      stream_on[s]   = 1'b0;
      bypass_left[s] = '0;
    end
    last_line[s] = line;
    if (stream_on[s] && bypass_left[s] != 0) bypass_left[s]--;
  endfunction

  function automatic void apply_access(int unsigned s, int unsigned w,
                                       bit [ADDR_W-1:0] addr, bit [SIGW-1:0] sig, bit hit);
    int unsigned   idx;
    bit [SIGW-1:0] old_sig;
    bit [1:0]      ins;
    idx = s * NWAYS + w;
    train_stride_detector(s, addr[ADDR_W-1:LINE_SHIFT]);
    if (hit) begin
      if (reuse_ctr[sig] != shiprrip_pkg::CNT_SAT) reuse_ctr[sig]++;
      rrpv_m[idx] = shiprrip_pkg::RRPV_HIT;
    end else begin
      // the evicted line's signature loses confidence first
      old_sig = wsig_m[idx];
      if (reuse_ctr[old_sig] != 0) reuse_ctr[old_sig]--;
      if (stream_on[s] && bypass_left[s] != 0) ins = shiprrip_pkg::RRPV_MAX;
      else if (reuse_ctr[sig] >= shiprrip_pkg::CNT_NEAR_TH) ins = shiprrip_pkg::RRPV_NEAR;
      else ins = shiprrip_pkg::RRPV_MAX;
      rrpv_m[idx] = ins;
      wsig_m[idx] = sig;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SIG_IN_W-1:0] pick_sig();
    if ($urandom_range(0, 99) < 85) return sig_pool[$urandom_range(0, 7)];
    return SIG_IN_W'($urandom);
  endfunction

  function automatic logic [SET_IN_W-1:0] pick_set();
    if ($urandom_range(0, 99) < 80) return hot_sets[$urandom_range(0, 7)];
    return SET_IN_W'($urandom);
  endfunction

  task automatic note_mismatch(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  task automatic add_req(shiprrip_pkg::cmd_e c, logic [SET_IN_W-1:0] s,
                         logic [WAY_IN_W-1:0] w, logic [ADDR_W-1:0] a,
                         logic [SIG_IN_W-1:0] g, logic h);
    llc_req_t r;
    r.cmd     = c;
    r.set_idx = s;
    r.way     = w;
    r.addr    = a;
    r.sig     = g;
    r.hit     = h;
    req_pending_q.push_back(r);
    n_queued++;
  endtask

  // victim transactions carry random filler in the unused fields
  task automatic add_victim(logic [SET_IN_W-1:0] s);
    add_req(shiprrip_pkg::CMD_VICTIM, s, WAY_IN_W'($urandom), ADDR_W'({$urandom, $urandom}),
            SIG_IN_W'($urandom), 1'($urandom));
  endtask

  task automatic write_window(logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    n_cfg_writes++;
  endtask

  // set idling for the phase; items are queued in this same posedge step
  task automatic begin_phase(bit src, bit sink, bit hold);
    @(posedge clk_i);
    src_gaps    = src;
    sink_stalls = sink;
    if (hold) hold_reqs++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (n_accepted != n_queued || victim_due_q.size() != 0);
    // updates produce no result, so give the pipeline time to retire them
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Mixed traffic: stride runs, victim/fill pairs, hit bursts and noise
  task automatic gen_traffic(int unsigned n, int unsigned victim_pct);
    int unsigned         made, kind, len;
    logic [SET_IN_W-1:0] s;
    logic [LINE_W-1:0]   line;
    bit                  down;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 99);
      s    = pick_set();
      if (kind < 45) begin
        len  = $urandom_range(2, 12);
        down = 1'($urandom);
        case ($urandom_range(0, 9))
          0:       line = LINE_W'($urandom_range(0, 2));
          1:       line = {LINE_W{1'b1}} - LINE_W'($urandom_range(0, 2));
          default: line = LINE_W'({$urandom, $urandom});
        endcase
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < victim_pct) begin
            add_victim(s);
            made++;
          end
          // occasionally break the run
          if ($urandom_range(0, 15) == 0) line = LINE_W'({$urandom, $urandom});
          add_req(shiprrip_pkg::CMD_UPDATE, s, WAY_IN_W'($urandom), {line, 6'($urandom)},
                  pick_sig(), $urandom_range(0, 3) == 0);
          made++;
          line = down ? line - 1'b1 : line + 1'b1;
        end
      end else if (kind < 70) begin
        add_victim(s);
        add_req(shiprrip_pkg::CMD_UPDATE, s, WAY_IN_W'($urandom),
                ADDR_W'({$urandom, $urandom}), pick_sig(), 1'b0);
        made += 2;
      end else if (kind < 88) begin
        len = $urandom_range(2, 6);
        for (int i = 0; i < len; i++)
          add_req(shiprrip_pkg::CMD_UPDATE, s, WAY_IN_W'($urandom),
                  ADDR_W'({$urandom, $urandom}), pick_sig(), 1'b1);
        made += len;
      end else begin
        add_req(shiprrip_pkg::cmd_e'($urandom_range(0, 1)), SET_IN_W'($urandom),
                WAY_IN_W'($urandom), ADDR_W'({$urandom, $urandom}), SIG_IN_W'($urandom),
                1'($urandom));
        made++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: presents queued transactions at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || req_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (req_pending_q.size() != 0) begin
        nxt = req_pending_q.pop_front();
        s_axis_tdata  <= {2'b00, nxt.hit, nxt.sig, nxt.addr, nxt.way, nxt.set_idx};
        s_axis_tuser  <= nxt.cmd;
        s_axis_tvalid <= 1'b1;
        gap_left = src_gaps ? pick_gap() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Victim sink: random stalls plus an occasional long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (holds_done != hold_reqs) begin
      holds_done = hold_reqs;
      hold_left  = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_stalls && stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_stalls) begin
      stall_left = pick_gap();
      if (stall_left == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on each accepted request, checks each victim transaction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fire = s_axis_tvalid && s_axis_tready;
      rsp_fire = m_axis_tvalid && m_axis_tready;
      if (cfg_we_i) window_len = cfg_wdata_i;

      if (req_fire) begin
        n_accepted++;
        if (shiprrip_pkg::cmd_e'(s_axis_tuser) == shiprrip_pkg::CMD_VICTIM) begin
          due.set_idx = s_axis_tdata[10:0];
          due.way     = pick_victim_way(32'(s_axis_tdata[10:0]));
          victim_due_q.push_back(due);
          n_victims++;
        end else begin
          apply_access(32'(s_axis_tdata[10:0]), 32'(s_axis_tdata[14:11]),
                       s_axis_tdata[62:15], s_axis_tdata[68:63], s_axis_tdata[69]);
          n_updates++;
        end
      end

      if (rsp_fire) begin
        if (victim_due_q.size() == 0) begin
          note_mismatch($sformatf("unexpected victim transaction, way %0d",
                                  m_axis_tdata[3:0]));
        end else begin
          due = victim_due_q.pop_front();
          if (m_axis_tdata[3:0] !== due.way)
            note_mismatch($sformatf("victim_way set %0d: expected %0d, got %0d",
                                    due.set_idx, due.way, m_axis_tdata[3:0]));
        end
      end

      // watchdog on transaction-free cycles
      if (req_fire || rsp_fire || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] win_sel  [NPHASES];
    bit               src_sel  [NPHASES];
    bit               sink_sel [NPHASES];
    bit               hold_sel [NPHASES];
    int unsigned      vic_sel  [NPHASES];

    win_sel  = '{4'd0, 4'd15, 4'd3, 4'd1, CFG_W'($urandom), shiprrip_pkg::WIN_RESET};
    src_sel  = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    sink_sel = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    hold_sel = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    vic_sel  = '{15, 20, 50, 15, 20, 20};

    // predictor reset state
    foreach (rrpv_m[i]) rrpv_m[i] = shiprrip_pkg::RRPV_MAX;
    foreach (reuse_ctr[i]) reuse_ctr[i] = shiprrip_pkg::CNT_INIT;
    window_len = shiprrip_pkg::WIN_RESET;
    sig_pool[0] = '0;
    sig_pool[1] = '1;
    for (int i = 2; i < 8; i++) sig_pool[i] = SIG_IN_W'($urandom);
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    for (int i = 2; i < 8; i++) hot_sets[i] = SET_IN_W'($urandom);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part
    write_window(4'd2);
    begin_phase(1'b1, 1'b1, 1'b0);
    add_victim(11'd0);
    add_req(shiprrip_pkg::CMD_UPDATE, 11'd2047, 4'd15, 48'hFFFF_FFFF_FFFF, 6'd63, 1'b1);
    add_req(shiprrip_pkg::CMD_UPDATE, 11'd0, 4'd0, 48'h0, 6'd0, 1'b0);
    // every way hit, so ageing finds no way at 3 and falls back to way 0
    for (int w = 0; w < NWAYS; w++)
      add_req(shiprrip_pkg::CMD_UPDATE, 11'd7, WAY_IN_W'(w), ADDR_W'((w * 37) << 6),
              SIG_IN_W'(w * 4), 1'b1);
    repeat (3) add_victim(11'd7);
    // descending unit strides ending on line zero, then a step off line zero
    add_req(shiprrip_pkg::CMD_UPDATE, 11'd3, 4'd1, 48'h0C5, 6'd9, 1'b0);
    add_req(shiprrip_pkg::CMD_UPDATE, 11'd3, 4'd2, 48'h080, 6'd9, 1'b0);
    add_req(shiprrip_pkg::CMD_UPDATE, 11'd3, 4'd3, 48'h07F, 6'd9, 1'b0);
    add_req(shiprrip_pkg::CMD_UPDATE, 11'd3, 4'd4, 48'h011, 6'd9, 1'b0);
    add_req(shiprrip_pkg::CMD_UPDATE, 11'd3, 4'd5, 48'h040, 6'd9, 1'b0);
    wait_drained();

    // Random phases, each under its own window setting and idling mix
    for (int p = 0; p < NPHASES; p++) begin
      write_window(win_sel[p]);
      begin_phase(src_sel[p], sink_sel[p], hold_sel[p]);
      gen_traffic(155, vic_sel[p]);
      wait_drained();
    end

    while (victim_due_q.size() != 0) begin
      due = victim_due_q.pop_front();
      note_mismatch($sformatf("victim for set %0d never arrived", due.set_idx));
    end

    $display("run covered %0d victim requests and %0d access updates over %0d window writes",
             n_victims, n_updates, n_cfg_writes);
    $display("%0d stream detections predicted, %0d mismatches", n_stream_starts, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/shiprrip_pkg.sv
hdl/ship_rrip_stream_bypass_policy_unit.sv
test/testbench.sv
